// ----- src/gphc_pkg.sv -----
// Shared types and constants of the gap-pair hit correlation histogrammer.
`default_nettype none

package gphc_pkg;

  localparam int OP_W      = 2;
  localparam int ARM_W     = 1;
  localparam int ORIENT_W  = 1;
  localparam int GAP_W     = 3;
  localparam int PANEL_W   = 3;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_HIT   = 2'd0,
    OP_EOE   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCAN_POS,
    ST_SCAN_HIST,
    ST_SCAN_WR,
    ST_CLEAR
  } back_state_e;

  // One queued command. The ok flag marks a read whose bin lies inside the histograms.
  typedef struct packed {
    op_e                 op;
    logic                ok;
    logic [ARM_W-1:0]    arm;
    logic [ORIENT_W-1:0] orientation;
    logic [GAP_W-1:0]    gap;
    logic [PANEL_W-1:0]  panel;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    partner_position;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

`default_nettype wire

// ----- src/gphc_if.sv -----
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface gphc_in_if;
  import gphc_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [ARM_W-1:0]    arm;
  logic [ORIENT_W-1:0] orientation;
  logic [GAP_W-1:0]    gap;
  logic [PANEL_W-1:0]  panel;
  logic [POS_W-1:0]    position;
  logic [POS_W-1:0]    partner_position;

  modport source (output valid, opcode, arm, orientation, gap, panel, position,
                  partner_position, input ready);
  modport sink (input valid, opcode, arm, orientation, gap, panel, position,
                partner_position, output ready);
endinterface

interface gphc_out_if;
  import gphc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink (input valid, bin_count, output ready);
endinterface

`default_nettype wire

// ----- src/gphc_front.sv -----
// Front end: accepts input words, range-checks them and pushes commands to the queue.
`default_nettype none

module gphc_front #(
  parameter int ARMS         = 2,
  parameter int ORIENTATIONS = 2,
  parameter int GAPS         = 5,
  parameter int PANELS       = 6,
  parameter int POSITIONS    = 64
) (
  gphc_in_if.sink               in_i,
  input  gphc_pkg::back_stat_t  stat_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output gphc_pkg::cmd_t        cmd_o
);
  import gphc_pkg::*;

  logic chan_ok;
  logic hit_ok;
  logic read_ok;
  op_e  op;

  assign op = op_e'(in_i.opcode);

  assign chan_ok = (32'(in_i.arm) < ARMS) && (32'(in_i.orientation) < ORIENTATIONS) &&
                   (32'(in_i.panel) < PANELS);
  assign hit_ok  = chan_ok && (32'(in_i.gap) < GAPS);
  assign read_ok = chan_ok && (32'(in_i.gap) < GAPS - 1) &&
                   (32'(in_i.position) < POSITIONS) &&
                   (32'(in_i.partner_position) < POSITIONS);

  // No word is taken while the histograms are still being cleared after reset.
  assign in_i.ready = !q_full_i && !stat_i.init_busy;

  // Hits outside the channel space are accepted and dropped here.
  assign push_o = in_i.valid && in_i.ready && ((op != OP_HIT) || hit_ok);

  always_comb begin
    cmd_o.op               = op;
    cmd_o.ok               = read_ok;
    cmd_o.arm              = in_i.arm;
    cmd_o.orientation      = in_i.orientation;
    cmd_o.gap              = in_i.gap;
    cmd_o.panel            = in_i.panel;
    cmd_o.position         = in_i.position;
    cmd_o.partner_position = in_i.partner_position;
  end

endmodule

`default_nettype wire

// ----- src/gphc_queue.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

module gphc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gphc_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output gphc_pkg::cmd_t head_o
);
  import gphc_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/gphc_back.sv -----
// Back end: per-event hit store, end-of-event pair scan, histogram memory and result register.
`default_nettype none

module gphc_back #(
  parameter int ARMS         = 2,
  parameter int ORIENTATIONS = 2,
  parameter int GAPS         = 5,
  parameter int PANELS       = 6,
  parameter int POSITIONS    = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  gphc_pkg::cmd_t       q_cmd_i,
  output logic                 q_pop_o,
  output gphc_pkg::back_stat_t stat_o,
  gphc_out_if.source           out_o
);
  import gphc_pkg::*;

  localparam int NCHAN    = ARMS * ORIENTATIONS * GAPS * PANELS;
  localparam int NHIST    = ARMS * ORIENTATIONS * (GAPS - 1) * PANELS;
  localparam int NBINS    = POSITIONS * POSITIONS;
  localparam int NWORDS   = NHIST * NBINS;
  localparam int CHAN_W   = $clog2(NCHAN);
  localparam int HIST_W   = (NHIST > 1) ? $clog2(NHIST) : 1;
  localparam int ADDR_W   = $clog2(NWORDS);
  localparam int GCNT_W   = (GAPS > 2) ? $clog2(GAPS - 1) : 1;
  localparam int PCNT_W   = (PANELS > 1) ? $clog2(PANELS) : 1;

  back_state_e state_q, state_d;

  // A channel has count one exactly when seen is set and multi is clear.
  logic [NCHAN-1:0] seen_q, seen_d;
  logic [NCHAN-1:0] multi_q, multi_d;

  logic [POS_W-1:0]   pos_mem [NCHAN];
  logic               pos_we;
  logic               pos_re;
  logic [POS_W-1:0]   pos_lo_q, pos_hi_q;

  logic [COUNT_W-1:0] hist_mem [NWORDS];
  logic               hist_we;
  logic               hist_re;
  logic [ADDR_W-1:0]  hist_waddr;
  logic [ADDR_W-1:0]  hist_raddr;
  logic [COUNT_W-1:0] hist_wdata;
  logic [COUNT_W-1:0] hist_rdata_q;

  logic [HIST_W-1:0]  hist_q, hist_d;
  logic [CHAN_W-1:0]  lo_q, lo_d;
  logic [GCNT_W-1:0]  gcnt_q, gcnt_d;
  logic [PCNT_W-1:0]  pcnt_q, pcnt_d;
  logic               pair_ok_q, pair_ok_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [ADDR_W-1:0]  waddr_q, waddr_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               init_q, init_d;
  logic               rd_ok_q, rd_ok_d;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  logic [CHAN_W-1:0]  hit_chan;
  logic [CHAN_W-1:0]  hi_chan;
  logic [ADDR_W-1:0]  read_addr;
  logic [ADDR_W-1:0]  scan_addr;
  logic [COUNT_W-1:0] sat_inc;
  logic               pair_in_range;
  logic               last_pair;
  logic               advance;

  assign hit_chan = CHAN_W'(((32'(q_cmd_i.arm) * ORIENTATIONS + 32'(q_cmd_i.orientation))
                             * GAPS + 32'(q_cmd_i.gap)) * PANELS + 32'(q_cmd_i.panel));

  assign read_addr = ADDR_W'((((32'(q_cmd_i.arm) * ORIENTATIONS + 32'(q_cmd_i.orientation))
                               * (GAPS - 1) + 32'(q_cmd_i.gap)) * PANELS
                              + 32'(q_cmd_i.panel)) * NBINS
                             + 32'(q_cmd_i.position) * POSITIONS
                             + 32'(q_cmd_i.partner_position));

  assign hi_chan   = CHAN_W'(32'(lo_q) + PANELS);
  assign scan_addr = ADDR_W'(32'(base_q) + 32'(pos_lo_q) * POSITIONS + 32'(pos_hi_q));
  assign sat_inc   = (&hist_rdata_q) ? hist_rdata_q : hist_rdata_q + COUNT_W'(1);
  assign last_pair = (hist_q == HIST_W'(NHIST - 1));

  assign pair_in_range = pair_ok_q && (32'(pos_lo_q) < POSITIONS) &&
                         (32'(pos_hi_q) < POSITIONS);

  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    multi_d     = multi_q;
    q_pop_o     = 1'b0;
    pos_we      = 1'b0;
    pos_re      = 1'b0;
    hist_we     = 1'b0;
    hist_re     = 1'b0;
    hist_waddr  = waddr_q;
    hist_raddr  = read_addr;
    hist_wdata  = sat_inc;
    hist_d      = hist_q;
    lo_d        = lo_q;
    gcnt_d      = gcnt_q;
    pcnt_d      = pcnt_q;
    pair_ok_d   = pair_ok_q;
    base_d      = base_q;
    waddr_d     = waddr_q;
    clr_d       = clr_q;
    init_d      = init_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_count_d = out_count_q;
    advance     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_cmd_i.op)
            OP_HIT: begin
              q_pop_o           = 1'b1;
              pos_we            = 1'b1;
              seen_d[hit_chan]  = 1'b1;
              multi_d[hit_chan] = multi_q[hit_chan] | seen_q[hit_chan];
            end
            OP_EOE: begin
              q_pop_o = 1'b1;
              hist_d  = '0;
              lo_d    = '0;
              gcnt_d  = '0;
              pcnt_d  = '0;
              state_d = ST_SCAN_POS;
            end
            OP_CLEAR: begin
              q_pop_o = 1'b1;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_READ: begin
              // The result register must be free, or be emptied in this cycle.
              if (!out_valid_q || out_o.ready) begin
                q_pop_o = 1'b1;
                hist_re = q_cmd_i.ok;
                rd_ok_d = q_cmd_i.ok;
                state_d = ST_READ_WAIT;
              end
            end
          endcase
        end
      end
      ST_READ_WAIT: begin
        out_valid_d = 1'b1;
        out_count_d = rd_ok_q ? hist_rdata_q : '0;
        state_d     = ST_IDLE;
      end
      ST_SCAN_POS: begin
        pos_re    = 1'b1;
        pair_ok_d = seen_q[lo_q] && !multi_q[lo_q] && seen_q[hi_chan] && !multi_q[hi_chan];
        base_d    = ADDR_W'(32'(hist_q) * NBINS);
        state_d   = ST_SCAN_HIST;
      end
      ST_SCAN_HIST: begin
        if (pair_in_range) begin
          hist_re    = 1'b1;
          hist_raddr = scan_addr;
          waddr_d    = scan_addr;
          state_d    = ST_SCAN_WR;
        end else begin
          advance = 1'b1;
        end
      end
      ST_SCAN_WR: begin
        hist_we = 1'b1;
        advance = 1'b1;
      end
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_q;
        hist_wdata = '0;
        if (clr_q == ADDR_W'(NWORDS - 1)) begin
          init_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Step to the next gap pair; the lower channel skips the last gap of each block.
    if (advance) begin
      if (last_pair) begin
        seen_d  = '0;
        multi_d = '0;
        state_d = ST_IDLE;
      end else begin
        hist_d  = hist_q + HIST_W'(1);
        state_d = ST_SCAN_POS;
        if (pcnt_q == PCNT_W'(PANELS - 1)) begin
          pcnt_d = '0;
          if (gcnt_q == GCNT_W'(GAPS - 2)) begin
            gcnt_d = '0;
            lo_d   = CHAN_W'(32'(lo_q) + PANELS + 1);
          end else begin
            gcnt_d = gcnt_q + GCNT_W'(1);
            lo_d   = lo_q + CHAN_W'(1);
          end
        end else begin
          pcnt_d = pcnt_q + PCNT_W'(1);
          lo_d   = lo_q + CHAN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      seen_q      <= '0;
      multi_q     <= '0;
      hist_q      <= '0;
      lo_q        <= '0;
      gcnt_q      <= '0;
      pcnt_q      <= '0;
      clr_q       <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      multi_q     <= multi_d;
      hist_q      <= hist_d;
      lo_q        <= lo_d;
      gcnt_q      <= gcnt_d;
      pcnt_q      <= pcnt_d;
      clr_q       <= clr_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_ok_q   <= pair_ok_d;
    base_q      <= base_d;
    waddr_q     <= waddr_d;
    rd_ok_q     <= rd_ok_d;
    out_count_q <= out_count_d;
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[hit_chan] <= q_cmd_i.position;
    end
    if (pos_re) begin
      pos_lo_q <= pos_mem[lo_q];
      pos_hi_q <= pos_mem[hi_chan];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rdata_q <= hist_mem[hist_raddr];
    end
  end

  assign stat_o.init_busy = init_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.bin_count  = out_count_q;

endmodule

`default_nettype wire

// ----- src/gap_pair_hit_correlation_histogrammer.sv -----
// Top level of the gap-pair hit correlation histogrammer.
//
//   Port    Dir  Fields                                                       Role
//   in_i    in   opcode arm orientation gap panel position partner_position  hit/event/clear/read
//   out_o   out  bin_count                                                    count of a read bin
//
// A word is taken in every cycle while the four-entry queue has room and the clearing pass
// after reset is over. A read loads its bin into the histogram read register and then into
// the result register. An end of event scans every gap pair in turn: it reads both positions,
// reads the histogram bin of a pair with a single hit in each channel inside the range, and
// writes back the saturated increment. The pass that follows reset writes one histogram word
// per cycle, all NHIST*POSITIONS*POSITIONS words, 393216 with the default sizes, and a clear
// word runs the same pass; no word is accepted during the pass after reset.
`default_nettype none

module gap_pair_hit_correlation_histogrammer #(
  parameter int ARMS         = 2,
  parameter int ORIENTATIONS = 2,
  parameter int GAPS         = 5,
  parameter int PANELS       = 6,
  parameter int POSITIONS    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gphc_in_if.sink     in_i,
  gphc_out_if.source  out_o
);
  import gphc_pkg::*;

  back_stat_t stat;
  logic       q_push;
  cmd_t       q_push_cmd;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  cmd_t       q_head;

  gphc_front #(
    .ARMS         (ARMS),
    .ORIENTATIONS (ORIENTATIONS),
    .GAPS         (GAPS),
    .PANELS       (PANELS),
    .POSITIONS    (POSITIONS)
  ) u_front (
    .in_i     (in_i),
    .stat_i   (stat),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (q_push_cmd)
  );

  gphc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  gphc_back #(
    .ARMS         (ARMS),
    .ORIENTATIONS (ORIENTATIONS),
    .GAPS         (GAPS),
    .PANELS       (PANELS),
    .POSITIONS    (POSITIONS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_head),
    .q_pop_o   (q_pop),
    .stat_o    (stat),
    .out_o     (out_o)
  );

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

  a_result_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(q_pop && (q_head.op == OP_READ), 2))
    else $error("result word without a read command two cycles earlier");

endmodule

`default_nettype wire
